@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ design/dgsp_pkg.sv @@
// Types and constants of the dense graph shortest path block.
// Depends on nothing.
package dgsp_pkg;

	localparam int NODES_DEF = 64;
	localparam int NODE_W = 6;
	localparam int WGT_W = 16;
	localparam int DIST_W = 22;

	localparam logic [WGT_W-1:0] NO_EDGE = '1;
	localparam logic [DIST_W-1:0] DIST_INF = '1;
	localparam logic [NODE_W-1:0] TARGET_LOW_RST = 6'd26;
	localparam logic [NODE_W-1:0] TARGET_HIGH_RST = 6'd50;

	localparam logic CFG_TARGET_LOW = 1'b0;
	localparam logic CFG_TARGET_HIGH = 1'b1;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_SOLVE = 2'd2
	} func_t;

	typedef struct packed {
		func_t             func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [WGT_W-1:0]  weight;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [NODE_W-1:0] nearest_node;
		logic [DIST_W-1:0] nearest_distance;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_ADD_WR2,
		ST_INIT,
		ST_SEL,
		ST_MARK,
		ST_RELAX,
		ST_SCAN
	} state_t;

endpackage

@@ design/dgsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dgsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/dense_graph_shortest_path_top.sv @@
// Top level of the dense graph shortest path block.
// Depends on dgsp_pkg and dgsp_ram.
//
// Usage:
//  - Command channel: cmd is a transfer when start is high and busy is low.
//    FUNC_CLEAR sets every edge to no-edge, FUNC_ADD stores a weight in both
//    directions when it is below the stored one, FUNC_SOLVE runs Dijkstra from
//    node_a and reports the nearest reachable node in [target_low, target_high],
//    source excluded. Other codes and out-of-range add endpoints are dropped.
//  - Result channel: res is valid for exactly one cycle while done is high.
//    Only a solve makes a result. The receiver cannot stall.
//  - Config: cfg_we writes target_low (index 0) or target_high (index 1).
//  - Solve: bound by the single read port of the distance RAM, one scan of
//    N = NODES entries per pick and one per relax pass. It stops picking when
//    no unvisited node is left reachable.
//  - Reset: the edge RAM is swept to no-edge, one entry a cycle, with busy
//    high. Config registers return to 26 and 50.
//  - Distance/visited RAM: written in full by each solve before it is read.
module dense_graph_shortest_path_top #(
	parameter int NODES = dgsp_pkg::NODES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dgsp_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done,
	output dgsp_pkg::res_t  res,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [dgsp_pkg::NODE_W-1:0] cfg_data
);

	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES * NODES);
	localparam int XW = ((IW > dgsp_pkg::NODE_W) ? IW : dgsp_pkg::NODE_W) + 1;
	localparam int DW = dgsp_pkg::DIST_W;
	localparam int WW = dgsp_pkg::WGT_W;
	localparam logic [IW-1:0] LAST = IW'(NODES - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(NODES * NODES - 1);

	typedef struct packed {
		logic          vis;
		logic [DW-1:0] dlen;
	} dv_t;

	// control and payload registers
	dgsp_pkg::state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] round_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          have_q;
	logic [DW-1:0] best_q;
	logic [IW-1:0] pick_q;
	logic [IW-1:0] a_q, b_q;
	logic [XW-1:0] src_q;
	logic [WW-1:0] w_q;
	logic [dgsp_pkg::NODE_W-1:0] tlo_q, thi_q;
	logic          done_q;
	dgsp_pkg::res_t res_q;

	// memory ports
	logic          ew_we;
	logic [AW-1:0] ew_waddr, ew_raddr;
	logic [WW-1:0] ew_wdata, ew_rdata;
	logic          dv_we;
	logic [IW-1:0] dv_waddr, dv_raddr;
	dv_t           dv_wdata, dv_rdata;

	logic          accept;
	logic          issue;
	logic [IW-1:0] idx;
	logic          last_rd;
	logic [DW:0]   sum;
	logic          relax_ok;
	logic          sel_upd, scan_upd;
	logic          in_range;
	logic          add_ok;

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		cell_addr = AW'(r) * AW'(NODES) + AW'(c);
	endfunction

	assign accept = start && (state_q == dgsp_pkg::ST_IDLE);
	assign busy = (state_q != dgsp_pkg::ST_IDLE);
	assign done = done_q;
	assign res = res_q;

	assign issue = (cnt_q < CW'(NODES));
	assign idx = cnt_q[IW-1:0];
	assign last_rd = vld_s1 && (idx_s1 == LAST);

	assign add_ok = (XW'(cmd.node_a) < XW'(NODES)) && (XW'(cmd.node_b) < XW'(NODES));

	// relax: candidate path through the picked node
	assign sum = {1'b0, best_q} + (DW + 1)'(ew_rdata);
	assign relax_ok = vld_s1 && !dv_rdata.vis && (ew_rdata != dgsp_pkg::NO_EDGE)
		&& (sum < {1'b0, dgsp_pkg::DIST_INF}) && (sum[DW-1:0] < dv_rdata.dlen);

	assign sel_upd = vld_s1 && !dv_rdata.vis && (dv_rdata.dlen < best_q);

	assign in_range = (XW'(idx_s1) >= XW'(tlo_q)) && (XW'(idx_s1) <= XW'(thi_q))
		&& (XW'(idx_s1) != src_q);
	assign scan_upd = vld_s1 && in_range && (dv_rdata.dlen < best_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dgsp_pkg::ST_CLR: begin
				if (clr_q == CLR_LAST) state_d = dgsp_pkg::ST_IDLE;
			end
			dgsp_pkg::ST_IDLE: begin
				if (accept) begin
					priority case (cmd.func)
						dgsp_pkg::FUNC_CLEAR: state_d = dgsp_pkg::ST_CLR;
						dgsp_pkg::FUNC_ADD: begin
							if (add_ok) state_d = dgsp_pkg::ST_ADD_RD;
						end
						dgsp_pkg::FUNC_SOLVE: state_d = dgsp_pkg::ST_INIT;
						default: state_d = dgsp_pkg::ST_IDLE;
					endcase
				end
			end
			dgsp_pkg::ST_ADD_RD: state_d = dgsp_pkg::ST_ADD_CMP;
			dgsp_pkg::ST_ADD_CMP: begin
				state_d = (w_q < ew_rdata) ? dgsp_pkg::ST_ADD_WR2 : dgsp_pkg::ST_IDLE;
			end
			dgsp_pkg::ST_ADD_WR2: state_d = dgsp_pkg::ST_IDLE;
			dgsp_pkg::ST_INIT: begin
				if (idx == LAST) state_d = dgsp_pkg::ST_SEL;
			end
			dgsp_pkg::ST_SEL: begin
				if (last_rd) begin
					state_d = (have_q || sel_upd) ? dgsp_pkg::ST_MARK : dgsp_pkg::ST_SCAN;
				end
			end
			dgsp_pkg::ST_MARK: state_d = dgsp_pkg::ST_RELAX;
			dgsp_pkg::ST_RELAX: begin
				if (last_rd) begin
					state_d = (round_q == LAST) ? dgsp_pkg::ST_SCAN : dgsp_pkg::ST_SEL;
				end
			end
			dgsp_pkg::ST_SCAN: begin
				if (last_rd) state_d = dgsp_pkg::ST_IDLE;
			end
			default: state_d = dgsp_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ew_we = 1'b0;
		ew_waddr = cell_addr(a_q, b_q);
		ew_wdata = w_q;
		ew_raddr = cell_addr(a_q, b_q);
		dv_we = 1'b0;
		dv_waddr = idx_s1;
		dv_wdata = '{vis: 1'b0, dlen: sum[DW-1:0]};
		dv_raddr = idx;
		unique case (state_q)
			dgsp_pkg::ST_CLR: begin
				ew_we = 1'b1;
				ew_waddr = clr_q;
				ew_wdata = dgsp_pkg::NO_EDGE;
			end
			dgsp_pkg::ST_ADD_CMP: begin
				ew_we = (w_q < ew_rdata);
			end
			dgsp_pkg::ST_ADD_WR2: begin
				ew_we = 1'b1;
				ew_waddr = cell_addr(b_q, a_q);
			end
			dgsp_pkg::ST_INIT: begin
				dv_we = 1'b1;
				dv_waddr = idx;
				dv_wdata = '{vis: 1'b0,
					dlen: (XW'(idx) == src_q) ? '0 : dgsp_pkg::DIST_INF};
			end
			dgsp_pkg::ST_MARK: begin
				dv_we = 1'b1;
				dv_waddr = pick_q;
				dv_wdata = '{vis: 1'b1, dlen: best_q};
			end
			dgsp_pkg::ST_RELAX: begin
				ew_raddr = cell_addr(pick_q, idx);
				dv_we = relax_ok;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgsp_pkg::ST_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			round_q <= '0;
			vld_s1 <= 1'b0;
			have_q <= 1'b0;
			done_q <= 1'b0;
			tlo_q <= dgsp_pkg::TARGET_LOW_RST;
			thi_q <= dgsp_pkg::TARGET_HIGH_RST;
		end else begin
			state_q <= state_d;
			// result strobe on the last scan read
			done_q <= (state_q == dgsp_pkg::ST_SCAN) && last_rd;
			// read pipe only runs in the three scanning states
			vld_s1 <= issue && ((state_q == dgsp_pkg::ST_SEL)
				|| (state_q == dgsp_pkg::ST_RELAX) || (state_q == dgsp_pkg::ST_SCAN));
			if (cfg_we) begin
				unique case (cfg_idx)
					dgsp_pkg::CFG_TARGET_LOW: tlo_q <= cfg_data;
					dgsp_pkg::CFG_TARGET_HIGH: thi_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				dgsp_pkg::ST_CLR: clr_q <= clr_q + AW'(1);
				dgsp_pkg::ST_IDLE: begin
					clr_q <= '0;
					cnt_q <= '0;
					round_q <= '0;
				end
				dgsp_pkg::ST_INIT: begin
					cnt_q <= (idx == LAST) ? '0 : cnt_q + CW'(1);
					have_q <= 1'b0;
				end
				dgsp_pkg::ST_SEL, dgsp_pkg::ST_RELAX, dgsp_pkg::ST_SCAN: begin
					if (issue) cnt_q <= cnt_q + CW'(1);
					if (state_q == dgsp_pkg::ST_SEL && sel_upd) have_q <= 1'b1;
					if (state_q == dgsp_pkg::ST_SCAN && scan_upd) have_q <= 1'b1;
					if (last_rd) begin
						cnt_q <= '0;
						if (state_q == dgsp_pkg::ST_RELAX) begin
							round_q <= round_q + IW'(1);
							have_q <= 1'b0;
						end
						if (state_q == dgsp_pkg::ST_SEL && !(have_q || sel_upd)) begin
							have_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		if (accept) begin
			a_q <= IW'(cmd.node_a);
			b_q <= IW'(cmd.node_b);
			src_q <= XW'(cmd.node_a);
			w_q <= cmd.weight;
		end
		unique case (state_q)
			dgsp_pkg::ST_INIT: best_q <= dgsp_pkg::DIST_INF;
			dgsp_pkg::ST_SEL: begin
				if (sel_upd) begin
					best_q <= dv_rdata.dlen;
					pick_q <= idx_s1;
				end
				// no pick left: start the report scan from scratch
				if (last_rd && !(have_q || sel_upd)) best_q <= dgsp_pkg::DIST_INF;
			end
			dgsp_pkg::ST_RELAX: begin
				if (last_rd) best_q <= dgsp_pkg::DIST_INF;
			end
			dgsp_pkg::ST_SCAN: begin
				if (scan_upd) begin
					best_q <= dv_rdata.dlen;
					pick_q <= idx_s1;
				end
				if (last_rd) begin
					res_q.found <= have_q || scan_upd;
					if (scan_upd) begin
						res_q.nearest_node <= dgsp_pkg::NODE_W'(idx_s1);
						res_q.nearest_distance <= dv_rdata.dlen;
					end else if (have_q) begin
						res_q.nearest_node <= dgsp_pkg::NODE_W'(pick_q);
						res_q.nearest_distance <= best_q;
					end else begin
						res_q.nearest_node <= '0;
						res_q.nearest_distance <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// adjacency matrix, row = from node
	dgsp_ram #(.WIDTH(WW), .DEPTH(NODES * NODES)) u_edge_ram (
		.clk   (clk),
		.we    (ew_we),
		.waddr (ew_waddr),
		.wdata (ew_wdata),
		.raddr (ew_raddr),
		.rdata (ew_rdata)
	);

	// distance and visited flag per node
	dgsp_ram #(.WIDTH(DW + 1), .DEPTH(NODES)) u_dist_ram (
		.clk   (clk),
		.we    (dv_we),
		.waddr (dv_waddr),
		.wdata (dv_wdata),
		.raddr (dv_raddr),
		.rdata (dv_rdata)
	);

endmodule

@@ design/dgsp_checker.sv @@
// Port-level checks for the dense graph shortest path block, bound to the top.
// Depends on dgsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dgsp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input dgsp_pkg::cmd_t cmd,
	input logic           busy,
	input logic           done
);

	logic solve_xfer;
	logic clear_xfer;

	assign solve_xfer = start && !busy && (cmd.func == dgsp_pkg::FUNC_SOLVE);
	assign clear_xfer = start && !busy && (cmd.func == dgsp_pkg::FUNC_CLEAR);

	`CHK_NEXT(a_done_single, clk, arst_n, done, !done)
	`CHK_SAME(a_done_idle, clk, arst_n, done, !busy)
	`CHK_NEXT(a_solve_busy, clk, arst_n, solve_xfer, busy && !done)
	`CHK_NEXT(a_clear_busy, clk, arst_n, clear_xfer, busy && !done)

endmodule

bind dense_graph_shortest_path_top dgsp_checker u_dgsp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done)
);
